FILE: design/s2a_pkg.sv
`default_nettype none

package s2a_pkg;

  // Scancode byte values.
  localparam logic [7:0] CodePrefix = 8'hE0;

  // Key codes, release bit stripped.
  localparam logic [6:0] KeyEscape = 7'h01;
  localparam logic [6:0] KeyCtrl   = 7'h1D;
  localparam logic [6:0] KeyLShift = 7'h2A;
  localparam logic [6:0] KeyRShift = 7'h36;
  localparam logic [6:0] KeyCaps   = 7'h3A;

  // Extended key codes, seen after the prefix byte.
  localparam logic [6:0] ExtHome     = 7'h47;
  localparam logic [6:0] ExtUp       = 7'h48;
  localparam logic [6:0] ExtPageUp   = 7'h49;
  localparam logic [6:0] ExtLeft     = 7'h4B;
  localparam logic [6:0] ExtRight    = 7'h4D;
  localparam logic [6:0] ExtEnd      = 7'h4F;
  localparam logic [6:0] ExtDown     = 7'h50;
  localparam logic [6:0] ExtPageDown = 7'h51;

  // Character values.
  localparam logic [6:0] CharEsc     = 7'h1B;
  localparam logic [6:0] CharBracket = 7'h5B;
  localparam logic [6:0] CharTilde   = 7'h7E;
  localparam logic [6:0] CaseDelta   = 7'd32;

  // Number of bytes one command can carry.
  localparam int unsigned SeqLen = 4;

  // One queued command: up to four bytes and the index of the final one.
  typedef struct packed {
    logic [1:0]             last_idx;
    logic [SeqLen-1:0][6:0] chars;
  } s2a_cmd_t;

  // US layout, no modifier.
  localparam logic [6:0] MapPlain [64] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // US layout with shift held.
  localparam logic [6:0] MapShift [64] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

endpackage

`default_nettype wire

FILE: design/scancode_to_ascii_translator_top.sv
`default_nettype none

// Channel  | Direction | Handshake              | Payload
// input    | in        | in_valid_i, in_stall_o | scancode_i[7:0]
// result   | out       | out_valid_o, out_stall_i | out_char_o[6:0], last_o
//
// A scancode is accepted in any cycle the command queue has room, so items
// can arrive back to back; a command is registered in the queue and then
// loaded from its head into the result register. The result side sends one
// byte per cycle while out_stall_i is low, so a key that gives an escape
// sequence holds the back end while it sends its three or four bytes.
// Reset clears the modifier flags, the queue and the result valid flag.
// A stalled result holds its byte while the queue keeps taking scancodes.

module scancode_to_ascii_translator_top
  import s2a_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] scancode_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [6:0]      out_char_o,
  output logic            last_o
);

  s2a_cmd_t push_cmd;
  s2a_cmd_t head_cmd;
  logic     push;
  logic     q_full;
  logic     head_valid;
  logic     pop;

  // Classify scancodes and track modifiers.
  s2a_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .scancode_i (scancode_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Commands waiting for the byte serializer.
  s2a_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (push_cmd),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head_cmd),
    .pop_i        (pop)
  );

  // Send each command's bytes one per cycle unless the result is stalled.
  s2a_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

FILE: design/s2a_front.sv
`default_nettype none

module s2a_front
  import s2a_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire logic [7:0] scancode_i,
  input  wire logic     q_full_i,
  output logic          push_o,
  output s2a_cmd_t      cmd_o
);

  logic       shift_q, shift_d;
  logic       ctrl_q, ctrl_d;
  logic       caps_q, caps_d;
  logic       prefix_q, prefix_d;
  logic       accept;
  logic [6:0] key;
  logic [6:0] plain_c;
  logic [6:0] shift_c;
  logic [6:0] map_c;
  logic [6:0] caps_c;
  logic       plain_lower;
  logic       plain_upper;
  logic       map_lower;
  logic       map_upper;

  // Items are taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign key        = scancode_i[6:0];

  // Table lookups; codes at or above 64 map to nothing.
  assign plain_c = key[6] ? 7'h00 : MapPlain[key[5:0]];
  assign shift_c = key[6] ? 7'h00 : MapShift[key[5:0]];
  assign map_c   = shift_q ? shift_c : plain_c;

  assign plain_lower = (plain_c >= 7'h61) && (plain_c <= 7'h7A);
  assign plain_upper = (plain_c >= 7'h41) && (plain_c <= 7'h5A);
  assign map_lower   = (map_c >= 7'h61) && (map_c <= 7'h7A);
  assign map_upper   = (map_c >= 7'h41) && (map_c <= 7'h5A);

  // Caps lock swaps the case of a letter once.
  always_comb begin
    caps_c = map_c;
    if (caps_q && map_lower) begin
      caps_c = map_c - CaseDelta;
    end else if (caps_q && map_upper) begin
      caps_c = map_c + CaseDelta;
    end
  end

  // Classify the item, update modifiers and build the queued command.
  always_comb begin
    shift_d  = shift_q;
    ctrl_d   = ctrl_q;
    caps_d   = caps_q;
    prefix_d = prefix_q;
    push_o   = 1'b0;
    cmd_o    = '0;
    cmd_o.chars[0] = CharEsc;
    cmd_o.chars[1] = CharBracket;
    if (accept) begin
      if (scancode_i == CodePrefix) begin
        prefix_d = 1'b1;
      end else begin
        prefix_d = 1'b0;
        if (scancode_i[7]) begin
          if (!prefix_q && (key == KeyLShift || key == KeyRShift)) begin
            shift_d = 1'b0;
          end
          if (key == KeyCtrl) begin
            ctrl_d = 1'b0;
          end
        end else if (prefix_q) begin
          cmd_o.last_idx = 2'd2;
          unique case (key)
            ExtUp: begin
              push_o = 1'b1;
              cmd_o.chars[2] = 7'h41;
            end
            ExtDown: begin
              push_o = 1'b1;
              cmd_o.chars[2] = 7'h42;
            end
            ExtRight: begin
              push_o = 1'b1;
              cmd_o.chars[2] = 7'h43;
            end
            ExtLeft: begin
              push_o = 1'b1;
              cmd_o.chars[2] = 7'h44;
            end
            ExtHome: begin
              push_o = 1'b1;
              cmd_o.chars[2] = 7'h48;
            end
            ExtEnd: begin
              push_o = 1'b1;
              cmd_o.chars[2] = 7'h46;
            end
            ExtPageUp: begin
              push_o = 1'b1;
              cmd_o.last_idx = 2'd3;
              cmd_o.chars[2] = 7'h35;
              cmd_o.chars[3] = CharTilde;
            end
            ExtPageDown: begin
              push_o = 1'b1;
              cmd_o.last_idx = 2'd3;
              cmd_o.chars[2] = 7'h36;
              cmd_o.chars[3] = CharTilde;
            end
            KeyCtrl: begin
              ctrl_d = 1'b1;
            end
            default: begin
            end
          endcase
        end else begin
          cmd_o.last_idx = 2'd0;
          priority if (key == KeyLShift || key == KeyRShift) begin
            shift_d = 1'b1;
          end else if (key == KeyCtrl) begin
            ctrl_d = 1'b1;
          end else if (key == KeyCaps) begin
            caps_d = !caps_q;
          end else if (key == KeyEscape) begin
            push_o = 1'b1;
            cmd_o.chars[0] = CharEsc;
          end else if (ctrl_q) begin
            // Letters become control codes 1 to 26.
            if (plain_lower) begin
              push_o = 1'b1;
              cmd_o.chars[0] = plain_c - 7'h60;
            end else if (plain_upper) begin
              push_o = 1'b1;
              cmd_o.chars[0] = plain_c - 7'h40;
            end
          end else begin
            push_o = (caps_c != 7'h00);
            cmd_o.chars[0] = caps_c;
          end
        end
      end
    end
  end

  // Modifier and prefix state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= 1'b0;
      ctrl_q   <= 1'b0;
      caps_q   <= 1'b0;
      prefix_q <= 1'b0;
    end else begin
      shift_q  <= shift_d;
      ctrl_q   <= ctrl_d;
      caps_q   <= caps_d;
      prefix_q <= prefix_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/s2a_queue.sv
`default_nettype none

module s2a_queue
  import s2a_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  s2a_cmd_t  cmd_i,
  output logic      full_o,
  output logic      head_valid_o,
  output s2a_cmd_t  head_o,
  input  wire logic pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  s2a_cmd_t        entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/s2a_back.sv
`default_nettype none

module s2a_back
  import s2a_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       head_valid_i,
  input  s2a_cmd_t        head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [6:0]      out_char_o,
  output logic            last_o
);

  logic       out_valid_q, out_valid_d;
  logic [6:0] out_char_q;
  logic       last_q;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic       is_last;

  // The output register takes a new byte when it is empty or being drained.
  assign load    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign is_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = is_last ? 2'd0 : idx_q + 2'd1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q <= head_i.chars[idx_q];
      last_q     <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import s2a_pkg::*;

  // One expected output byte and its end-of-sequence flag.
  typedef struct packed {
    logic [6:0] ch;
    logic       fin;
  } char_exp_t;

  // One directed key item; has_char tells whether a typed row gives a byte.
  typedef struct packed {
    logic [7:0] code;
    logic       typed;
    logic       has_char;
    logic [6:0] ch;
  } key_row_t;

  localparam int NumRows = 25;
  localparam int RandomKeys = 255;
  localparam int QuietAfter = 240;
  localparam int DrainCycles = 20;

  // Tail characters of the escape sequences.
  localparam logic [6:0] TailUp    = 7'h41;
  localparam logic [6:0] TailDown  = 7'h42;
  localparam logic [6:0] TailRight = 7'h43;
  localparam logic [6:0] TailLeft  = 7'h44;
  localparam logic [6:0] TailEnd   = 7'h46;
  localparam logic [6:0] TailHome  = 7'h48;
  localparam logic [6:0] TailPgUp  = 7'h35;
  localparam logic [6:0] TailPgDn  = 7'h36;

  // Directed keys: typed rows carry their byte, the rest go to the predictor.
  localparam key_row_t KeyRows [NumRows] = '{
    '{8'h1E, 1'b1, 1'b1, 7'h61},  // plain 'a' right after reset
    '{8'h00, 1'b1, 1'b0, 7'h00},  // lowest code, empty table entry
    '{8'hFF, 1'b1, 1'b0, 7'h00},  // highest code, a release
    '{8'h01, 1'b1, 1'b1, 7'h1B},  // escape key
    '{8'h2A, 1'b0, 1'b0, 7'h00},  // left shift down
    '{8'h1E, 1'b0, 1'b0, 7'h00},
    '{8'h3A, 1'b0, 1'b0, 7'h00},  // caps lock on
    '{8'h1E, 1'b0, 1'b0, 7'h00},  // shift and caps give lower case
    '{8'h02, 1'b0, 1'b0, 7'h00},
    '{8'hAA, 1'b0, 1'b0, 7'h00},  // left shift up
    '{8'h1E, 1'b0, 1'b0, 7'h00},
    '{8'h1D, 1'b0, 1'b0, 7'h00},  // ctrl down
    '{8'h2C, 1'b1, 1'b1, 7'h1A},  // ctrl z
    '{8'h01, 1'b1, 1'b1, 7'h1B},  // escape still wins over ctrl
    '{8'h9D, 1'b0, 1'b0, 7'h00},  // ctrl up
    '{8'hE0, 1'b0, 1'b0, 7'h00},
    '{8'hE0, 1'b0, 1'b0, 7'h00},  // a second prefix keeps the flag
    '{8'h49, 1'b0, 1'b0, 7'h00},  // page up, four bytes
    '{8'hE0, 1'b0, 1'b0, 7'h00},
    '{8'h1D, 1'b0, 1'b0, 7'h00},  // right ctrl down
    '{8'hE0, 1'b0, 1'b0, 7'h00},
    '{8'h9D, 1'b0, 1'b0, 7'h00},  // right ctrl up
    '{8'hE0, 1'b0, 1'b0, 7'h00},
    '{8'h50, 1'b0, 1'b0, 7'h00},  // down arrow
    '{8'h7F, 1'b1, 1'b0, 7'h00}   // key past the end of the table
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] scancode_i = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [6:0] out_char_o;
  logic       last_o;

  // Predictor state.
  logic shift_down = 1'b0;
  logic ctrl_down = 1'b0;
  logic caps_lock = 1'b0;
  logic after_prefix = 1'b0;

  char_exp_t expected_chars [$];
  int        mismatches = 0;
  int        sent_keys = 0;
  bit        idle_on = 1'b1;

  scancode_to_ascii_translator_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .scancode_i (scancode_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_char_o (out_char_o),
    .last_o     (last_o)
  );

  // Clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Queue the bytes of an escape sequence.
  task automatic add_escape_seq(input logic [6:0] tail, input logic tilde);
    expected_chars.push_back(char_exp_t'{CharEsc, 1'b0});
    expected_chars.push_back(char_exp_t'{CharBracket, 1'b0});
    expected_chars.push_back(char_exp_t'{tail, ~tilde});
    if (tilde) begin
      expected_chars.push_back(char_exp_t'{CharTilde, 1'b1});
    end
  endtask

  // Work out the bytes one accepted scancode gives and update the key state.
  task automatic predict_key(input logic [7:0] code);
    logic [6:0] key;
    logic       ext;
    logic [6:0] ch;
    key = code[6:0];
    if (code == CodePrefix) begin
      after_prefix = 1'b1;
      return;
    end
    ext = after_prefix;
    after_prefix = 1'b0;
    if (code[7]) begin
      // Releases only drop shift or ctrl.
      if (!ext && (key == KeyLShift || key == KeyRShift)) shift_down = 1'b0;
      if (key == KeyCtrl) ctrl_down = 1'b0;
    end else if (ext) begin
      case (key)
        ExtUp:       add_escape_seq(TailUp, 1'b0);
        ExtDown:     add_escape_seq(TailDown, 1'b0);
        ExtRight:    add_escape_seq(TailRight, 1'b0);
        ExtLeft:     add_escape_seq(TailLeft, 1'b0);
        ExtHome:     add_escape_seq(TailHome, 1'b0);
        ExtEnd:      add_escape_seq(TailEnd, 1'b0);
        ExtPageUp:   add_escape_seq(TailPgUp, 1'b1);
        ExtPageDown: add_escape_seq(TailPgDn, 1'b1);
        KeyCtrl:     ctrl_down = 1'b1;
        default: ;
      endcase
    end else if (key == KeyLShift || key == KeyRShift) begin
      shift_down = 1'b1;
    end else if (key == KeyCtrl) begin
      ctrl_down = 1'b1;
    end else if (key == KeyCaps) begin
      caps_lock = ~caps_lock;
    end else if (key == KeyEscape) begin
      expected_chars.push_back(char_exp_t'{CharEsc, 1'b1});
    end else if (ctrl_down) begin
      // With ctrl held only letters give a control code.
      ch = key[6] ? 7'h00 : MapPlain[key[5:0]];
      if (ch >= 7'h61 && ch <= 7'h7A) begin
        expected_chars.push_back(char_exp_t'{ch - 7'h60, 1'b1});
      end else if (ch >= 7'h41 && ch <= 7'h5A) begin
        expected_chars.push_back(char_exp_t'{ch - 7'h40, 1'b1});
      end
    end else begin
      if (key[6]) ch = 7'h00;
      else if (shift_down) ch = MapShift[key[5:0]];
      else ch = MapPlain[key[5:0]];
      // Caps lock swaps the case of a letter once.
      if (caps_lock) begin
        if (ch >= 7'h61 && ch <= 7'h7A) ch = ch - CaseDelta;
        else if (ch >= 7'h41 && ch <= 7'h5A) ch = ch + CaseDelta;
      end
      if (ch != 7'h00) expected_chars.push_back(char_exp_t'{ch, 1'b1});
    end
  endtask

  // Offer one scancode, with an optional gap first, and wait for acceptance.
  task automatic offer_key(input logic [7:0] code);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    scancode_i <= code;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Account for one accepted scancode.
  task automatic note_key(input logic [7:0] code);
    predict_key(code);
    sent_keys++;
    idle_on = (sent_keys < QuietAfter);
  endtask

  // Send one scancode and predict its bytes.
  task automatic send_key(input logic [7:0] code);
    offer_key(code);
    note_key(code);
  endtask

  // Send a directed row; typed rows replace the predicted bytes.
  task automatic send_row(input key_row_t row);
    int depth;
    offer_key(row.code);
    depth = expected_chars.size();
    note_key(row.code);
    if (row.typed) begin
      while (expected_chars.size() > depth) void'(expected_chars.pop_back());
      if (row.has_char) expected_chars.push_back(char_exp_t'{row.ch, 1'b1});
    end
  endtask

  // One random keystroke, mostly well formed, sometimes noise.
  task automatic send_random_stroke();
    int         pick;
    logic [7:0] ext_codes [10];
    logic [7:0] rel_codes [3];
    ext_codes = '{8'h48, 8'h50, 8'h4D, 8'h4B, 8'h47, 8'h4F, 8'h49, 8'h51,
                  8'h1D, 8'h9D};
    rel_codes = '{8'hAA, 8'hB6, 8'h9D};
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_key(8'($urandom_range(8'h00, 8'h3F)));
    end else if (pick < 55) begin
      if ($urandom_range(0, 1) == 0) send_key(rel_codes[$urandom_range(0, 2)]);
      else send_key(8'($urandom_range(8'h80, 8'hFF)));
    end else if (pick < 65) begin
      case ($urandom_range(0, 3))
        0: send_key({1'b0, KeyLShift});
        1: send_key({1'b0, KeyRShift});
        2: send_key({1'b0, KeyCtrl});
        default: send_key({1'b0, KeyCaps});
      endcase
    end else if (pick < 85) begin
      send_key(CodePrefix);
      if ($urandom_range(0, 4) != 0) send_key(ext_codes[$urandom_range(0, 9)]);
      else send_key(8'($urandom_range(0, 255)));
    end else begin
      send_key(8'($urandom_range(0, 255)));
    end
  endtask

  // Stimulus and end of run.
  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumRows; i++) begin
      send_row(KeyRows[i]);
    end
    while (sent_keys < NumRows + RandomKeys) begin
      send_random_stroke();
    end
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: check each accepted byte and stall in random bursts.
  initial begin : result_side
    int        stall_left;
    char_exp_t want;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual char %h last %b",
                   $time, out_char_o, last_o);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char_o !== want.ch) begin
            $display("%0t: out_char expected %h actual %h",
                     $time, want.ch, out_char_o);
            mismatches++;
          end
          if (last_o !== want.fin) begin
            $display("%0t: last expected %b actual %b", $time, want.fin, last_o);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
